@@ src/mmed_pkg.sv @@
package mmed_pkg;

   localparam int SAMPLE_WIDTH    = 16;
   localparam int X_WIDTH         = 24;
   localparam int Y_WIDTH         = 17;
   localparam int CFG_WIDTH       = 16;
   localparam int MID_WIDTH       = 12;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int DIV_STEP_WIDTH  = 4;

   // register map
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INTERVAL = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SCALE    = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MID      = 2'd2;

   localparam logic [CFG_WIDTH-1:0] INTERVAL_RESET = 16'd512;
   localparam logic [CFG_WIDTH-1:0] SCALE_RESET    = 16'd163;
   localparam logic [MID_WIDTH-1:0] MID_RESET      = 12'd200;

   // which record value the shared divider is working on
   typedef logic [1:0] op_sel_type;
   localparam op_sel_type OP_START  = 2'd0;
   localparam op_sel_type OP_FIRST  = 2'd1;
   localparam op_sel_type OP_SECOND = 2'd2;

   typedef struct packed {
      logic       accept;
      logic       div_start;
      op_sel_type div_sel;
      logic       publish;
   } mmed_cmd_type;

   typedef struct packed {
      logic emit_due;
      logic div_done;
   } mmed_status_type;

endpackage

@@ src/mmed_div.sv @@
module mmed_div
   import mmed_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [SAMPLE_WIDTH-1:0] dividend,
   input  logic [SAMPLE_WIDTH-1:0] divisor,
   output logic                    done,
   output logic [SAMPLE_WIDTH-1:0] quotient
);

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [SAMPLE_WIDTH:0]     rem_ff, rem_in;
   logic [SAMPLE_WIDTH-1:0]   quo_ff, quo_in;
   logic [SAMPLE_WIDTH-1:0]   dsr_ff, dsr_in;
   logic [DIV_STEP_WIDTH-1:0] cnt_ff, cnt_in;
   logic [SAMPLE_WIDTH:0]     trial;
   logic                      last_step;

   // restoring divide, one quotient bit per cycle, MSB first
   always_comb begin
      trial     = {rem_ff[SAMPLE_WIDTH-1:0], quo_ff[SAMPLE_WIDTH-1]};
      last_step = cnt_ff == DIV_STEP_WIDTH'(SAMPLE_WIDTH - 1);
      busy_in   = busy_ff;
      done_in   = 1'b0;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dsr_in    = dsr_ff;
      cnt_in    = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
         cnt_in  = '0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = trial - {1'b0, dsr_ff};
            quo_in = {quo_ff[SAMPLE_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[SAMPLE_WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ src/mmed_dp.sv @@
module mmed_dp
   import mmed_pkg::*;
#(
   parameter int POS_WIDTH = 24
)
(
   input  logic                           clock,
   input  logic                           reset,
   input  mmed_cmd_type                   cmd,
   output mmed_status_type                status,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample,
   input  logic                           csr_write,
   input  logic [CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [CFG_WIDTH-1:0]           csr_data,
   output logic [X_WIDTH-1:0]             rsp_start_x,
   output logic signed [Y_WIDTH-1:0]      rsp_start_y,
   output logic [X_WIDTH-1:0]             rsp_first_x,
   output logic signed [Y_WIDTH-1:0]      rsp_first_y,
   output logic [X_WIDTH-1:0]             rsp_second_x,
   output logic signed [Y_WIDTH-1:0]      rsp_second_y
);

   // config
   logic [CFG_WIDTH-1:0] interval_ff;
   logic [CFG_WIDTH-1:0] scale_ff;
   logic [MID_WIDTH-1:0] mid_ff;

   // running state
   logic signed [SAMPLE_WIDTH-1:0] peak_ff, peak_in;
   logic [POS_WIDTH-1:0]           peak_pos_ff, peak_pos_in;
   logic signed [SAMPLE_WIDTH-1:0] trough_ff, trough_in;
   logic [POS_WIDTH-1:0]           trough_pos_ff, trough_pos_in;
   logic [POS_WIDTH-1:0]           prev_x_ff;
   logic signed [SAMPLE_WIDTH-1:0] prev_val_ff;
   logic [POS_WIDTH-1:0]           pos_ff;
   logic [CFG_WIDTH-1:0]           count_ff;

   logic signed [SAMPLE_WIDTH-1:0] first_val, second_val;
   logic [POS_WIDTH-1:0]           pos_plus1, pos_plus2;
   logic                           emit_now;

   // record snapshot while the divider runs
   logic signed [SAMPLE_WIDTH-1:0] op_start_ff, op_first_ff, op_second_ff;
   logic [POS_WIDTH-1:0]           snap_start_x_ff, snap_first_x_ff, snap_second_x_ff;
   logic signed [Y_WIDTH-1:0]      y_start_ff, y_first_ff, y_second_ff;

   // divider operands
   logic signed [SAMPLE_WIDTH-1:0] op_cur;
   logic                           op_neg;
   logic [SAMPLE_WIDTH-1:0]        op_mag;
   logic [SAMPLE_WIDTH-1:0]        divisor_eff;
   logic                           div_done;
   logic [SAMPLE_WIDTH-1:0]        quotient;
   logic signed [Y_WIDTH-1:0]      q_signed, y_value;

   // output register
   logic [POS_WIDTH-1:0]      out_start_x_ff, out_first_x_ff, out_second_x_ff;
   logic signed [Y_WIDTH-1:0] out_start_y_ff, out_first_y_ff, out_second_y_ff;
   logic [POS_WIDTH+X_WIDTH-1:0] start_x_ext, first_x_ext, second_x_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= INTERVAL_RESET;
         scale_ff    <= SCALE_RESET;
         mid_ff      <= MID_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_INTERVAL: interval_ff <= csr_data;
            CSR_SCALE:    scale_ff    <= csr_data;
            CSR_MID:      mid_ff      <= csr_data[MID_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      peak_in       = peak_ff;
      peak_pos_in   = peak_pos_ff;
      trough_in     = trough_ff;
      trough_pos_in = trough_pos_ff;
      if (req_sample > peak_ff) begin
         peak_in     = req_sample;
         peak_pos_in = pos_ff;
      end else if (req_sample < trough_ff) begin
         trough_in     = req_sample;
         trough_pos_in = pos_ff;
      end
      // the extreme with the later tag is drawn second; ties put the trough first
      if (trough_pos_in > peak_pos_in) begin
         first_val  = peak_in;
         second_val = trough_in;
      end else begin
         first_val  = trough_in;
         second_val = peak_in;
      end
      pos_plus1 = pos_ff + 1'b1;
      pos_plus2 = pos_ff + POS_WIDTH'(2);
      emit_now  = count_ff >= interval_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff       <= '0;
         peak_pos_ff   <= '0;
         trough_ff     <= '0;
         trough_pos_ff <= '0;
         prev_x_ff     <= '0;
         prev_val_ff   <= '0;
         pos_ff        <= '0;
         count_ff      <= '0;
      end else if (cmd.accept) begin
         if (emit_now) begin
            peak_ff       <= '0;
            peak_pos_ff   <= '0;
            trough_ff     <= '0;
            trough_pos_ff <= '0;
            prev_x_ff     <= pos_plus1;
            prev_val_ff   <= second_val;
            pos_ff        <= pos_plus2;
            count_ff      <= '0;
         end else begin
            peak_ff       <= peak_in;
            peak_pos_ff   <= peak_pos_in;
            trough_ff     <= trough_in;
            trough_pos_ff <= trough_pos_in;
            count_ff      <= count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && emit_now) begin
         op_start_ff      <= prev_val_ff;
         op_first_ff      <= first_val;
         op_second_ff     <= second_val;
         snap_start_x_ff  <= prev_x_ff;
         snap_first_x_ff  <= pos_ff;
         snap_second_x_ff <= pos_plus1;
      end
   end

   always_comb begin
      case (cmd.div_sel)
         OP_START:  op_cur = op_start_ff;
         OP_FIRST:  op_cur = op_first_ff;
         OP_SECOND: op_cur = op_second_ff;
         default:   op_cur = op_second_ff;
      endcase
      op_neg      = op_cur[SAMPLE_WIDTH-1];
      op_mag      = op_neg ? (~op_cur + 1'b1) : op_cur;
      divisor_eff = (scale_ff == '0) ? SAMPLE_WIDTH'(1) : scale_ff;
      q_signed    = op_neg ? -$signed({1'b0, quotient}) : $signed({1'b0, quotient});
      y_value     = $signed({{(Y_WIDTH-MID_WIDTH){1'b0}}, mid_ff}) + q_signed;
   end

   mmed_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (op_mag),
      .divisor  (divisor_eff),
      .done     (div_done),
      .quotient (quotient)
   );

   always_ff @(posedge clock) begin
      if (div_done) begin
         case (cmd.div_sel)
            OP_START:  y_start_ff  <= y_value;
            OP_FIRST:  y_first_ff  <= y_value;
            default:   y_second_ff <= y_value;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         out_start_x_ff  <= snap_start_x_ff;
         out_first_x_ff  <= snap_first_x_ff;
         out_second_x_ff <= snap_second_x_ff;
         out_start_y_ff  <= y_start_ff;
         out_first_y_ff  <= y_first_ff;
         out_second_y_ff <= y_second_ff;
      end
   end

   // x ports carry the low 24 bits of the position, zero-filled if narrower
   assign start_x_ext  = {{X_WIDTH{1'b0}}, out_start_x_ff};
   assign first_x_ext  = {{X_WIDTH{1'b0}}, out_first_x_ff};
   assign second_x_ext = {{X_WIDTH{1'b0}}, out_second_x_ff};

   assign rsp_start_x  = start_x_ext[X_WIDTH-1:0];
   assign rsp_first_x  = first_x_ext[X_WIDTH-1:0];
   assign rsp_second_x = second_x_ext[X_WIDTH-1:0];
   assign rsp_start_y  = out_start_y_ff;
   assign rsp_first_y  = out_first_y_ff;
   assign rsp_second_y = out_second_y_ff;

   assign status.emit_due = emit_now;
   assign status.div_done = div_done;

endmodule

@@ src/mmed_ctrl.sv @@
module mmed_ctrl
   import mmed_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   input  mmed_status_type status,
   output mmed_cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_RUN,
      ST_DIVIDE,
      ST_PUBLISH
   } ctrl_state_type;

   ctrl_state_type state_ff;
   logic           div_start_ff;
   op_sel_type     sel_ff;
   logic           rsp_valid_ff;
   logic           accept, publish, rsp_taken;

   always_comb begin
      accept        = (state_ff == ST_RUN) && req_valid;
      rsp_taken     = rsp_valid_ff && !rsp_stall;
      publish       = (state_ff == ST_PUBLISH) && (!rsp_valid_ff || !rsp_stall);
      req_stall     = state_ff != ST_RUN;
      cmd.accept    = accept;
      cmd.div_start = div_start_ff;
      cmd.div_sel   = sel_ff;
      cmd.publish   = publish;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         div_start_ff <= 1'b0;
         sel_ff       <= OP_START;
         rsp_valid_ff <= 1'b0;
      end else begin
         div_start_ff <= 1'b0;
         // a publish in the same cycle refills the output register
         if (rsp_taken && !publish) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_RUN: begin
               if (accept && status.emit_due) begin
                  state_ff     <= ST_DIVIDE;
                  sel_ff       <= OP_START;
                  div_start_ff <= 1'b1;
               end
            end
            ST_DIVIDE: begin
               if (status.div_done) begin
                  if (sel_ff == OP_SECOND) begin
                     state_ff <= ST_PUBLISH;
                  end else begin
                     sel_ff       <= sel_ff + 1'b1;
                     div_start_ff <= 1'b1;
                  end
               end
            end
            ST_PUBLISH: begin
               if (publish) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_RUN;
               end
            end
            default: state_ff <= ST_RUN;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ src/minmax_envelope_decimator.sv @@
//  channel | ports                           | direction | moves
//  --------+---------------------------------+-----------+-------------------------------
//  req     | req_valid/req_stall/req_sample  | in        | one audio sample per request
//  rsp     | rsp_valid/rsp_stall/rsp_*_x/_y  | out       | one polyline record per transfer
//  csr     | csr_write/csr_index/csr_data    | in        | register write, no read-back
//
//  A request that does not close an interval is taken in the cycle it is offered;
//  back-to-back requests are taken every cycle while no record is being made or held back.
//  After a closing request, three scaled values go one after the other through a shared 16-step divider.
//  Reset (synchronous) clears the extremes, position and count and loads register
//  defaults. A finished record waits in the output register under rsp_stall while
//  further requests are taken; a new record waits in ST_PUBLISH, stalling requests, until it is free.
module minmax_envelope_decimator
   import mmed_pkg::*;
#(
   parameter int POS_WIDTH = 24
)
(
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample,
   // record channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [X_WIDTH-1:0]             rsp_start_x,
   output logic signed [Y_WIDTH-1:0]      rsp_start_y,
   output logic [X_WIDTH-1:0]             rsp_first_x,
   output logic signed [Y_WIDTH-1:0]      rsp_first_y,
   output logic [X_WIDTH-1:0]             rsp_second_x,
   output logic signed [Y_WIDTH-1:0]      rsp_second_y,
   // register writes
   input  logic                           csr_write,
   input  logic [CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [CFG_WIDTH-1:0]           csr_data
);

   // controller <-> datapath: commands down, status up
   mmed_cmd_type    cmd;
   mmed_status_type status;

   // Controller: runs the request handshake, sequences the three divisions
   // (previous end, first extreme, second extreme) and owns rsp_valid.
   mmed_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: registers, running peak/trough with position tags, record
   // snapshot, shared divider with mid-level offset, and the output register.
   mmed_dp #(
      .POS_WIDTH (POS_WIDTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_sample   (req_sample),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .rsp_start_x  (rsp_start_x),
      .rsp_start_y  (rsp_start_y),
      .rsp_first_x  (rsp_first_x),
      .rsp_first_y  (rsp_first_y),
      .rsp_second_x (rsp_second_x),
      .rsp_second_y (rsp_second_y)
   );

endmodule

@@ src/mmed_chk.sv @@
module mmed_chk
   import mmed_pkg::*;
#(
   parameter int POS_WIDTH = 24
)
(
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic signed [SAMPLE_WIDTH-1:0] req_sample,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [X_WIDTH-1:0]             rsp_start_x,
   input logic signed [Y_WIDTH-1:0]      rsp_start_y,
   input logic [X_WIDTH-1:0]             rsp_first_x,
   input logic signed [Y_WIDTH-1:0]      rsp_first_y,
   input logic [X_WIDTH-1:0]             rsp_second_x,
   input logic signed [Y_WIDTH-1:0]      rsp_second_y,
   input logic                           csr_write,
   input logic [CSR_INDEX_WIDTH-1:0]     csr_index,
   input logic [CFG_WIDTH-1:0]           csr_data
);

   logic [X_WIDTH-1:0] last_end_x_ff;
   logic [X_WIDTH-1:0] next_x;

   // end point of the last delivered record starts the next one
   always_ff @(posedge clock) begin
      if (reset) begin
         last_end_x_ff <= '0;
      end else if (rsp_valid && !rsp_stall) begin
         last_end_x_ff <= rsp_second_x;
      end
   end

   if (POS_WIDTH < X_WIDTH) begin : g_narrow
      assign next_x = X_WIDTH'(POS_WIDTH'(rsp_first_x[POS_WIDTH-1:0] + 1'b1));
   end else begin : g_wide
      assign next_x = rsp_first_x + 1'b1;
   end

   a_second_follows_first: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_second_x == next_x)
      else $error("second_x is not first_x plus one");

   a_segments_chain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_start_x == last_end_x_ff)
      else $error("record does not start at previous end point");

   a_record_after_divide: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("record published without a division phase");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_start_x) && $stable(rsp_start_y)
         && $stable(rsp_first_x) && $stable(rsp_first_y)
         && $stable(rsp_second_x) && $stable(rsp_second_y))
      else $error("stalled record changed");

endmodule

bind minmax_envelope_decimator mmed_chk #(.POS_WIDTH(POS_WIDTH)) u_chk (.*);

@@ test/envelope_checker.sv @@
module envelope_checker
   import mmed_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [X_WIDTH-1:0]             rsp_start_x,
   input  logic signed [Y_WIDTH-1:0]      rsp_start_y,
   input  logic [X_WIDTH-1:0]             rsp_first_x,
   input  logic signed [Y_WIDTH-1:0]      rsp_first_y,
   input  logic [X_WIDTH-1:0]             rsp_second_x,
   input  logic signed [Y_WIDTH-1:0]      rsp_second_y,
   input  logic                           csr_write,
   input  logic [CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [CFG_WIDTH-1:0]           csr_data,
   output int                             error_count,
   output int                             records_due
);

   typedef struct packed {
      logic [X_WIDTH-1:0] start_x;
      logic [Y_WIDTH-1:0] start_y;
      logic [X_WIDTH-1:0] first_x;
      logic [Y_WIDTH-1:0] first_y;
      logic [X_WIDTH-1:0] second_x;
      logic [Y_WIDTH-1:0] second_y;
   } envelope_record_type;

   // register copies
   logic [CFG_WIDTH-1:0] emit_at;
   logic [CFG_WIDTH-1:0] divisor;
   logic [MID_WIDTH-1:0] baseline;

   // envelope state; x positions wrap at the 24-bit output width
   logic signed [SAMPLE_WIDTH-1:0] hi_value, lo_value, last_value;
   logic [X_WIDTH-1:0]             hi_tag, lo_tag, last_x, cur_x;
   logic [CFG_WIDTH-1:0]           count;

   envelope_record_type due_records[$];
   envelope_record_type seen, wanted, made;
   logic                made_valid;

   function automatic logic [Y_WIDTH-1:0] to_screen(input logic signed [SAMPLE_WIDTH-1:0] v);
      int d;
      int y;
      d = (divisor == '0) ? 1 : int'(divisor);
      y = int'(baseline) + int'(v) / d;   // int division truncates toward zero
      return y[Y_WIDTH-1:0];
   endfunction

   function automatic string describe(input envelope_record_type r);
      return $sformatf("start (%0d,%0d) first (%0d,%0d) second (%0d,%0d)",
                       r.start_x, $signed(r.start_y), r.first_x, $signed(r.first_y),
                       r.second_x, $signed(r.second_y));
   endfunction

   task automatic envelope_step(input logic signed [SAMPLE_WIDTH-1:0] s,
                                output logic fired, output envelope_record_type rec);
      logic signed [SAMPLE_WIDTH-1:0] early, late;
      logic [X_WIDTH-1:0]             next_x;
      fired = 1'b0;
      rec   = '0;
      if (s > hi_value) begin
         hi_value = s;
         hi_tag   = cur_x;
      end else if (s < lo_value) begin
         lo_value = s;
         lo_tag   = cur_x;
      end
      if (count < emit_at) begin
         count = count + 1'b1;
         return;
      end
      // trough first unless its tag is strictly later than the peak's
      if (lo_tag > hi_tag) begin
         early = hi_value;
         late  = lo_value;
      end else begin
         early = lo_value;
         late  = hi_value;
      end
      next_x       = cur_x + 1'b1;
      rec.start_x  = last_x;
      rec.start_y  = to_screen(last_value);
      rec.first_x  = cur_x;
      rec.first_y  = to_screen(early);
      rec.second_x = next_x;
      rec.second_y = to_screen(late);
      fired        = 1'b1;
      last_x       = next_x;
      last_value   = late;
      hi_value     = '0;
      hi_tag       = '0;
      lo_value     = '0;
      lo_tag       = '0;
      count        = '0;
      cur_x        = next_x + 1'b1;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         emit_at     = INTERVAL_RESET;
         divisor     = SCALE_RESET;
         baseline    = MID_RESET;
         hi_value    = '0;
         hi_tag      = '0;
         lo_value    = '0;
         lo_tag      = '0;
         last_x      = '0;
         last_value  = '0;
         cur_x       = '0;
         count       = '0;
         error_count = 0;
         due_records.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen.start_x  = rsp_start_x;
            seen.start_y  = rsp_start_y;
            seen.first_x  = rsp_first_x;
            seen.first_y  = rsp_first_y;
            seen.second_x = rsp_second_x;
            seen.second_y = rsp_second_y;
            if (due_records.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("unexpected record: %s", describe(seen));
            end else begin
               wanted = due_records.pop_front();
               if (seen.start_x !== wanted.start_x || seen.start_y !== wanted.start_y ||
                   seen.first_x !== wanted.first_x || seen.first_y !== wanted.first_y ||
                   seen.second_x !== wanted.second_x ||
                   seen.second_y !== wanted.second_y) begin
                  error_count++;
                  if (error_count <= 10) begin
                     $display("record mismatch: expected %s", describe(wanted));
                     $display("                 actual   %s", describe(seen));
                  end
               end
            end
         end
         if (csr_write) begin
            case (csr_index)
               CSR_INTERVAL: emit_at  = csr_data;
               CSR_SCALE:    divisor  = csr_data;
               CSR_MID:      baseline = csr_data[MID_WIDTH-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            envelope_step(req_sample, made_valid, made);
            if (made_valid)
               due_records.push_back(made);
         end
      end
      records_due = due_records.size();
   end

endmodule

@@ test/tb_minmax_envelope_decimator.sv @@
module tb_minmax_envelope_decimator;
   import mmed_pkg::*;

   // long receiver hold-off, to fill the output register and the controller
   localparam int HOLD_OFF_CYCLES = 400;
   // settle time before writes, long enough for a closing request to finish
   localparam int SETTLE_CYCLES   = 80;
   localparam int RANDOM_PHASES   = 8;
   localparam int PHASE_REQUESTS  = 50;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   logic signed [SAMPLE_WIDTH-1:0] req_sample;
   logic                           rsp_valid;
   logic                           rsp_stall;
   logic [X_WIDTH-1:0]             rsp_start_x;
   logic signed [Y_WIDTH-1:0]      rsp_start_y;
   logic [X_WIDTH-1:0]             rsp_first_x;
   logic signed [Y_WIDTH-1:0]      rsp_first_y;
   logic [X_WIDTH-1:0]             rsp_second_x;
   logic signed [Y_WIDTH-1:0]      rsp_second_y;
   logic                           csr_write;
   logic [CSR_INDEX_WIDTH-1:0]     csr_index;
   logic [CFG_WIDTH-1:0]           csr_data;

   int error_count;
   int records_due;
   bit calm;       // no idling on either side
   bit hold_off;   // asks the receiver for one long hold-off

   minmax_envelope_decimator uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_sample   (req_sample),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_start_x  (rsp_start_x),
      .rsp_start_y  (rsp_start_y),
      .rsp_first_x  (rsp_first_x),
      .rsp_first_y  (rsp_first_y),
      .rsp_second_x (rsp_second_x),
      .rsp_second_y (rsp_second_y),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   // watches all three ports, predicts each record and compares
   envelope_checker checker_i (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_sample   (req_sample),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_start_x  (rsp_start_x),
      .rsp_start_y  (rsp_start_y),
      .rsp_first_x  (rsp_first_x),
      .rsp_first_y  (rsp_first_y),
      .rsp_second_x (rsp_second_x),
      .rsp_second_y (rsp_second_y),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .error_count  (error_count),
      .records_due  (records_due)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // One request per call, entered and left at a falling edge. Valid stays
   // high on return so back-to-back requests never drop it; a random gap
   // lowers it first.
   task automatic feed(input logic signed [SAMPLE_WIDTH-1:0] s);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // stop offering, let every expected record arrive, then give the block
   // time to finish any closing request before registers are touched
   task automatic settle();
      req_valid <= 1'b0;
      wait (records_due == 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // all three registers on consecutive cycles; the unused upper bits of the
   // mid level write carry junk, which the block must ignore
   task automatic write_config(input logic [CFG_WIDTH-1:0] interval,
                               input logic [CFG_WIDTH-1:0] scale,
                               input logic [MID_WIDTH-1:0] mid);
      logic [CFG_WIDTH-1:0] junk;
      junk      = CFG_WIDTH'($urandom);
      csr_write <= 1'b1;
      csr_index <= CSR_INTERVAL;
      csr_data  <= interval;
      @(negedge clock);
      csr_index <= CSR_SCALE;
      csr_data  <= scale;
      @(negedge clock);
      csr_index <= CSR_MID;
      csr_data  <= {junk[CFG_WIDTH-1:MID_WIDTH], mid};
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   // full-scale values and small ones near zero turn up more often than
   // uniform draws would give
   function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0:       return {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
         1:       return {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
         2:       return SAMPLE_WIDTH'($urandom_range(0, 40)) - SAMPLE_WIDTH'(20);
         default: return SAMPLE_WIDTH'($urandom);
      endcase
   endfunction

   // Receiver: each decision holds for a stretch. Random stall bursts,
   // quiet stretches between, and one long hold-off on request from the
   // stimulus.
   initial begin
      int stretch;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_stall <= 1'b1;
            stretch   = HOLD_OFF_CYCLES;
            hold_off  = 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            stretch   = $urandom_range(1, 12);
         end else begin
            rsp_stall <= 1'b0;
            stretch   = $urandom_range(1, 20);
         end
         repeat (stretch) @(negedge clock);
      end
   end

   initial begin
      int                   phase;
      int                   n;
      logic [CFG_WIDTH-1:0] interval;
      logic [CFG_WIDTH-1:0] scale;
      logic [MID_WIDTH-1:0] mid;
      req_valid  = 1'b0;
      req_sample = '0;
      csr_write  = 1'b0;
      csr_index  = CSR_INTERVAL;
      csr_data   = '0;
      calm       = 1'b0;
      hold_off   = 1'b0;
      reset      = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // register defaults: extremes of the sample, no record yet
      feed(16'sh7FFF);
      feed(-16'sh8000);
      feed(16'sh0000);
      feed(16'sh0001);
      feed(-16'sh0001);
      settle();

      // longest interval, then lowered below the running count: the next
      // request closes the interval at once, scaled with the default divisor
      write_config(16'hFFFF, SCALE_RESET, MID_RESET);
      feed(16'sh1234);
      feed(-16'sh4321);
      feed(16'sh0000);
      settle();
      write_config(16'd2, SCALE_RESET, MID_RESET);
      feed(16'sh0064);
      settle();

      // zero interval: a record per request; zero divisor acts as one,
      // with the highest mid level
      write_config('0, '0, {MID_WIDTH{1'b1}});
      feed(16'sh7FFF);
      feed(-16'sh8000);
      feed(16'sh0000);
      feed(-16'sh0001);
      settle();

      // divisor one with zero offset: the lowest vertical value
      write_config('0, 16'd1, '0);
      feed(-16'sh8000);
      feed(16'sh7FFF);
      feed(16'sh0005);
      feed(16'sh0000);
      settle();

      // largest divisor, so every scaled value collapses to the offset
      write_config(16'd1, 16'hFFFF, 12'd2048);
      feed(16'sh7FFF);
      feed(-16'sh8000);
      feed(-16'sh0005);
      feed(16'sh0007);
      settle();

      // random phases, short intervals mostly so records come often
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case ($urandom_range(0, 9))
            0:       interval = 16'hFFFF;
            1, 2:    interval = '0;
            default: interval = CFG_WIDTH'($urandom_range(1, 6));
         endcase
         case ($urandom_range(0, 5))
            0:       scale = '0;
            1:       scale = 16'd1;
            2:       scale = 16'hFFFF;
            3:       scale = CFG_WIDTH'($urandom_range(1, 200));
            default: scale = CFG_WIDTH'($urandom);
         endcase
         case ($urandom_range(0, 4))
            0:       mid = '0;
            1:       mid = {MID_WIDTH{1'b1}};
            default: mid = MID_WIDTH'($urandom);
         endcase
         // one phase with a record per request while the receiver holds
         // off, so the block backs up and stalls its requests
         if (phase == 1) begin
            interval = '0;
            hold_off = 1'b1;
         end
         // the closing phase runs without idling on either side
         if (phase == RANDOM_PHASES - 1)
            calm = 1'b1;
         write_config(interval, scale, mid);
         for (n = 0; n < PHASE_REQUESTS; n++)
            feed(pick_sample());
         settle();
      end

      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // run limit
   initial begin
      #(20 * 400000);
      $display("DONE: errors detected");
      $finish;
   end

endmodule

@@ sim.f @@
src/mmed_pkg.sv
src/mmed_div.sv
src/mmed_dp.sv
src/mmed_ctrl.sv
src/minmax_envelope_decimator.sv
src/mmed_chk.sv
test/envelope_checker.sv
test/tb_minmax_envelope_decimator.sv
